// ===== rtl/thw_pkg.sv =====
package thw_pkg;

    // Channel count limits and default
    localparam int THW_NUM_CHANNELS = 32;
    localparam int THW_MAX_CHANNELS = 32;

    // Field widths
    localparam int CMD_W   = 2;
    localparam int CHAN_W  = 5;
    localparam int STALL_W = 11;
    localparam int LIMIT_W = 10;
    localparam int FAILS_W = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [STALL_W-1:0] STALL_MAX   = 11'h7FF;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd50;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_KICK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_STOP  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_START = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MONITOR_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_MASK   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STALL_LIMIT    = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [CHAN_W-1:0] channel;
    } thw_req_t;

    typedef struct packed {
        logic               wdt_clear;
        logic               reboot_request;
        logic               device_error;
        logic [FAILS_W-1:0] failing_count;
        logic [CHAN_W-1:0]  last_failing_channel;
    } thw_result_t;

    // Outcome of one channel visit, from the stall unit to the store
    typedef struct packed {
        logic               wr;
        logic               clr_kick;
        logic [STALL_W-1:0] count;
        logic               fail;
    } thw_step_t;

endpackage

// ===== rtl/thw_stall_unit.sv =====
module thw_stall_unit
    import thw_pkg::*;
(
    input  logic               enabled,
    input  logic               kicked,
    input  logic [STALL_W-1:0] count,
    input  logic [LIMIT_W-1:0] limit,
    output thw_step_t          step
);

    logic [STALL_W-1:0] inc_count;

    // Saturating increment of the stall count
    always_comb
    begin
        if (count == STALL_MAX)
        begin
            inc_count = count;
        end
        else
        begin
            inc_count = count + STALL_W'(1);
        end
    end

    // Kicked channel is cleared, unkicked one stalls and may fail
    always_comb
    begin
        step.wr       = enabled;
        step.clr_kick = enabled && kicked;
        step.count    = kicked ? '0 : inc_count;
        step.fail     = enabled && !kicked && (inc_count > {1'b0, limit});
    end

endmodule

// ===== rtl/thw_chan_store.sv =====
module thw_chan_store
    import thw_pkg::*;
#(
    parameter int NUM_CHANNELS = THW_NUM_CHANNELS,
    localparam int IdxW = $clog2(NUM_CHANNELS > 1 ? NUM_CHANNELS : 2)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               kick_en,
    input  logic [IdxW-1:0]    kick_idx,
    input  logic               walk_en,
    input  logic [IdxW-1:0]    walk_idx,
    input  thw_step_t          step,
    output logic               rd_kicked,
    output logic [STALL_W-1:0] rd_count
);

    logic [NUM_CHANNELS-1:0] kicked_reg;
    logic [STALL_W-1:0]      stall_reg [NUM_CHANNELS];

    assign rd_kicked = kicked_reg[walk_idx];
    assign rd_count  = stall_reg[walk_idx];

    // Per-channel kick marks and stall counts
    for (genvar i = 0; i < NUM_CHANNELS; i++)
    begin : g_chan
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                kicked_reg[i] <= 1'b0;
                stall_reg[i]  <= '0;
            end
            else
            begin
                if (kick_en && kick_idx == IdxW'(i))
                begin
                    kicked_reg[i] <= 1'b1;
                end
                else if (walk_en && walk_idx == IdxW'(i) && step.clr_kick)
                begin
                    kicked_reg[i] <= 1'b0;
                end
                if (walk_en && walk_idx == IdxW'(i) && step.wr)
                begin
                    stall_reg[i] <= step.count;
                end
            end
        end
    end

endmodule

// ===== rtl/task_heartbeat_watchdog_core.sv =====
// Kick, stop and start requests give no result.
// A tick with monitoring off gives its result in the cycle after acceptance.
// A tick with monitoring on visits one channel a cycle through one shared
// stall unit while busy, and gives its result in the cycle after the last visit.
// The result strobe lasts one cycle; the receiver cannot stall it.
// Reset clears all kick marks, stall counts and flags; config registers return to defaults.
module task_heartbeat_watchdog_core
    import thw_pkg::*;
#(
    parameter int NUM_CHANNELS = THW_NUM_CHANNELS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  thw_req_t              req,
    output logic                  done,
    output thw_result_t           result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int IdxW = $clog2(NUM_CHANNELS > 1 ? NUM_CHANNELS : 2);
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WALK = 1'b1;

    logic                  state_reg, state_next;
    logic [IdxW-1:0]       idx_reg, idx_next;
    logic [FAILS_W-1:0]    fails_reg, fails_next;
    logic [CHAN_W-1:0]     last_reg, last_next;
    logic                  run_reg, run_next;
    logic                  dev_err_reg, dev_err_next;
    logic                  done_reg, done_next;
    thw_result_t           result_reg, result_next;

    logic                  mon_en_reg;
    logic [31:0]           mask_reg;
    logic [LIMIT_W-1:0]    limit_reg;

    logic                  accept;
    logic                  kick_en;
    logic                  walk_en;
    logic                  last_step;
    logic                  rd_kicked;
    logic [STALL_W-1:0]    rd_count;
    thw_step_t             step;
    logic [FAILS_W-1:0]    fails_now;
    logic [CHAN_W-1:0]     last_now;

    assign busy      = (state_reg == ST_WALK);
    assign done      = done_reg;
    assign result    = result_reg;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;
    assign walk_en   = busy;
    assign last_step = (idx_reg == IdxW'(NUM_CHANNELS - 1));
    assign kick_en   = accept && (req.command == CMD_KICK)
                       && ({1'b0, req.channel} < (CHAN_W + 1)'(NUM_CHANNELS));

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mon_en_reg <= 1'b0;
            mask_reg   <= '0;
            limit_reg  <= LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_MONITOR_ENABLE: mon_en_reg <= cfg_data[0];
                REG_CHANNEL_MASK:   mask_reg   <= cfg_data;
                REG_STALL_LIMIT:    limit_reg  <= cfg_data[LIMIT_W-1:0];
                default:            ;
            endcase
        end
    end

    thw_chan_store #(
        .NUM_CHANNELS(NUM_CHANNELS)
    ) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .kick_en   (kick_en),
        .kick_idx  (req.channel[IdxW-1:0]),
        .walk_en   (walk_en),
        .walk_idx  (idx_reg),
        .step      (step),
        .rd_kicked (rd_kicked),
        .rd_count  (rd_count)
    );

    thw_stall_unit u_stall (
        .enabled (mask_reg[idx_reg]),
        .kicked  (rd_kicked),
        .count   (rd_count),
        .limit   (limit_reg),
        .step    (step)
    );

    // Running totals including the channel visited this cycle
    assign fails_now = fails_reg + FAILS_W'(step.fail);
    assign last_now  = step.fail ? CHAN_W'(idx_reg) : last_reg;

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        fails_next   = fails_reg;
        last_next    = last_reg;
        run_next     = run_reg;
        dev_err_next = dev_err_reg;
        done_next    = 1'b0;
        result_next  = result_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (req.command)
                        CMD_STOP:  run_next = 1'b0;
                        CMD_START: run_next = 1'b1;
                        CMD_TICK:
                        begin
                            if (mon_en_reg)
                            begin
                                state_next = ST_WALK;
                                idx_next   = '0;
                                fails_next = '0;
                                last_next  = '0;
                            end
                            else
                            begin
                                done_next   = 1'b1;
                                result_next = '{wdt_clear:            1'b0,
                                                reboot_request:       !run_reg,
                                                device_error:         dev_err_reg,
                                                failing_count:        '0,
                                                last_failing_channel: '0};
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_WALK:
            begin
                fails_next = fails_now;
                last_next  = last_now;
                idx_next   = idx_reg + IdxW'(1);
                if (last_step)
                begin
                    state_next   = ST_IDLE;
                    idx_next     = '0;
                    dev_err_next = (fails_now != '0);
                    done_next    = 1'b1;
                    result_next  = '{wdt_clear:            (fails_now == '0) && run_reg,
                                     reboot_request:       1'b0,
                                     device_error:         (fails_now != '0),
                                     failing_count:        fails_now,
                                     last_failing_channel: last_now};
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            run_reg     <= 1'b0;
            dev_err_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            run_reg     <= run_next;
            dev_err_reg <= dev_err_next;
            done_reg    <= done_next;
        end
    end

    // Accumulators and result payload
    always_ff @(posedge clk)
    begin
        fails_reg  <= fails_next;
        last_reg   <= last_next;
        result_reg <= result_next;
    end

endmodule

// ===== rtl/thw_checker.sv =====
module thw_checker
    import thw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  thw_req_t    req,
    input  logic        done,
    input  thw_result_t result
);

    // A result never shows while a walk is still running
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // Only a tick produces a result
    a_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req.command != CMD_TICK) |=> !done)
        else $error("result after a non-tick request");

    // Reboot mode carries no channel figures
    a_reboot: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.reboot_request) |->
        (!result.wdt_clear && result.failing_count == '0
         && result.last_failing_channel == '0))
        else $error("reboot result with channel figures");

    // Failures raise the error flag and hold off the watchdog refresh
    a_fail_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.failing_count != '0) |->
        (result.device_error && !result.wdt_clear))
        else $error("failure without error flag");

    // No failing channel named when nothing failed
    a_last_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.failing_count == '0) |-> result.last_failing_channel == '0)
        else $error("failing channel without failures");

endmodule

bind task_heartbeat_watchdog_core thw_checker u_thw_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .req    (req),
    .done   (done),
    .result (result)
);
